/* sv/bnms_pkg.sv */
package bnms_pkg;

    localparam int COORD_W   = 16;
    localparam int THR_W     = 17;
    localparam int SLOT_W    = 6;
    localparam logic [THR_W-1:0] THR_RESET = 17'd32768;

    typedef struct packed {
        logic [COORD_W-1:0] x0;
        logic [COORD_W-1:0] y0;
        logic [COORD_W-1:0] x1;
        logic [COORD_W-1:0] y1;
        logic [COORD_W-1:0] sc;
    } t_box;

    // controller to datapath
    typedef struct packed {
        logic store;
        logic box_rd;
        logic box_by_rank;
        logic score_ld;
        logic rank_rd;
        logic rank_wr;
        logic a_ld;
        logic span_ld;
        logic mul_ld;
        logic uni_ld;
        logic thr_ld;
        logic mark_clr_all;
        logic mark_set;
        logic out_ld;
        logic out_ovf;
        logic out_last;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic sc_gt;
        logic sc_eq;
        logic mark_at;
        logic hit;
        logic out_taken;
    } t_sts;

endpackage

/* sv/bnms_dp.sv */
module bnms_dp
    import bnms_pkg::*;
#(
    parameter int MAX_BOXES = 64,
    parameter int IW        = $clog2(MAX_BOXES)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  logic [IW-1:0]      i_box_idx,
    input  logic [IW-1:0]      i_rank_idx,
    input  logic [IW-1:0]      i_rank_wdata,
    input  logic [IW-1:0]      i_mark_idx,
    input  t_box               i_box,
    input  logic               i_cfg_valid,
    input  logic [THR_W-1:0]   i_cfg_data,
    input  logic               i_out_ready,
    output t_sts               o_sts,
    output logic               o_out_valid,
    output t_box               o_out_box,
    output logic [SLOT_W-1:0]  o_out_slot,
    output logic               o_out_ovf,
    output logic               o_out_last
);

    t_box              r_box_mem [MAX_BOXES];
    logic [IW-1:0]     r_rank_mem [MAX_BOXES];
    t_box              r_box_q;
    logic [IW-1:0]     r_rank_q;
    logic [MAX_BOXES-1:0] r_marks;
    logic [THR_W-1:0]  r_thr;
    logic [COORD_W-1:0] r_score_i;
    t_box              r_a;
    logic [COORD_W-1:0] r_sx, r_sy, r_sax, r_say, r_sbx, r_sby;
    logic [2*COORD_W-1:0] r_inter, r_area_a, r_area_b;
    logic [2*COORD_W:0] r_uni;
    logic [THR_W+THR_W-1:0] r_p_lo;
    logic [THR_W+COORD_W-1:0] r_p_hi;
    logic              r_out_valid;
    t_box              r_out_box;
    logic [SLOT_W-1:0] r_out_slot;
    logic              r_out_ovf, r_out_last;

    logic [IW-1:0]     box_raddr;
    logic [COORD_W-1:0] ix0, iy0, ix1, iy1;
    logic [50:0]       rhs, lhs;

    function automatic logic [COORD_W-1:0] span(input logic [COORD_W-1:0] lo,
                                                 input logic [COORD_W-1:0] hi);
        span = (hi > lo) ? (hi - lo) : '0;
    endfunction

    assign box_raddr = i_cmd.box_by_rank ? r_rank_q : i_box_idx;

    always_ff @(posedge i_clk) begin
        if (i_cmd.store) r_box_mem[i_box_idx] <= i_box;
        if (i_cmd.box_rd) r_box_q <= r_box_mem[box_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rank_wr) r_rank_mem[i_rank_idx] <= i_rank_wdata;
        if (i_cmd.rank_rd) r_rank_q <= r_rank_mem[i_rank_idx];
    end

    assign ix0 = (r_a.x0 > r_box_q.x0) ? r_a.x0 : r_box_q.x0;
    assign iy0 = (r_a.y0 > r_box_q.y0) ? r_a.y0 : r_box_q.y0;
    assign ix1 = (r_a.x1 < r_box_q.x1) ? r_a.x1 : r_box_q.x1;
    assign iy1 = (r_a.y1 < r_box_q.y1) ? r_a.y1 : r_box_q.y1;

    // overlap*65536 >= thr*union, thr*union in two partial products
    assign rhs = {r_p_hi, 17'b0} + 51'(r_p_lo);
    assign lhs = 51'({r_inter, 16'b0});

    always_ff @(posedge i_clk) begin
        if (i_cmd.score_ld) r_score_i <= r_box_q.sc;
        if (i_cmd.a_ld) r_a <= r_box_q;
        if (i_cmd.span_ld) begin
            r_sx  <= span(ix0, ix1);
            r_sy  <= span(iy0, iy1);
            r_sax <= span(r_a.x0, r_a.x1);
            r_say <= span(r_a.y0, r_a.y1);
            r_sbx <= span(r_box_q.x0, r_box_q.x1);
            r_sby <= span(r_box_q.y0, r_box_q.y1);
        end
        if (i_cmd.mul_ld) begin
            r_inter  <= r_sx * r_sy;
            r_area_a <= r_sax * r_say;
            r_area_b <= r_sbx * r_sby;
        end
        if (i_cmd.uni_ld) begin
            r_uni <= 33'(r_area_a) + 33'(r_area_b) - 33'(r_inter);
        end
        if (i_cmd.thr_ld) begin
            r_p_lo <= r_thr * r_uni[16:0];
            r_p_hi <= r_thr * r_uni[32:17];
        end
        if (i_cmd.out_ld) begin
            r_out_box  <= r_box_q;
            r_out_slot <= SLOT_W'(r_rank_q);
            r_out_ovf  <= i_cmd.out_ovf;
            r_out_last <= i_cmd.out_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr       <= THR_RESET;
            r_marks     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) r_thr <= i_cfg_data;
            if (i_cmd.mark_clr_all) r_marks <= '0;
            else if (i_cmd.mark_set) r_marks[i_mark_idx] <= 1'b1;
            if (i_cmd.out_ld) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    assign o_sts.sc_gt     = r_box_q.sc > r_score_i;
    assign o_sts.sc_eq     = r_box_q.sc == r_score_i;
    assign o_sts.mark_at   = r_marks[i_mark_idx];
    assign o_sts.hit       = (r_inter == '0) ? (r_thr == '0) : (lhs >= rhs);
    assign o_sts.out_taken = r_out_valid & i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_box   = r_out_box;
    assign o_out_slot  = r_out_slot;
    assign o_out_ovf   = r_out_ovf;
    assign o_out_last  = r_out_last;

endmodule

/* sv/bnms_ctrl.sv */
module bnms_ctrl
    import bnms_pkg::*;
#(
    parameter int MAX_BOXES = 64,
    parameter int IW        = $clog2(MAX_BOXES),
    parameter int CW        = $clog2(MAX_BOXES + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_final,
    output logic          o_in_ready,
    input  t_sts          i_sts,
    output t_cmd          o_cmd,
    output logic [IW-1:0] o_box_idx,
    output logic [IW-1:0] o_rank_idx,
    output logic [IW-1:0] o_rank_wdata,
    output logic [IW-1:0] o_mark_idx
);

    typedef enum logic [4:0] {
        LOAD, SORT_RDI, SORT_LDI, SORT_RDJ, SORT_CMPJ, SORT_WR,
        SUP_CHK, SUP_RA, SUP_LA, PAIR_CHK, P_RB, P_SPAN, P_MUL, P_UNI, P_THR, P_CMP,
        SCAN, EMIT_CHK, EMIT_RB, EMIT_LD, EMIT_WAIT
    } t_state;

    t_state        r_state;
    logic [CW-1:0] r_count, r_n, r_i, r_j;
    logic [IW-1:0] r_cnt, r_last;
    logic          r_ovf;
    logic          in_acc, has_room;
    logic [CW-1:0] i_nxt, j_nxt;

    assign in_acc   = i_in_valid && (r_state == LOAD);
    assign has_room = r_count < CW'(MAX_BOXES);
    assign i_nxt    = r_i + CW'(1);
    assign j_nxt    = r_j + CW'(1);
    assign o_in_ready = (r_state == LOAD);

    always_comb begin
        o_cmd        = '0;
        o_box_idx    = r_i[IW-1:0];
        o_rank_idx   = r_i[IW-1:0];
        o_rank_wdata = r_i[IW-1:0];
        o_mark_idx   = r_i[IW-1:0];
        o_cmd.out_ovf  = r_ovf;
        o_cmd.out_last = (r_i[IW-1:0] == r_last);
        unique case (r_state)
            LOAD: begin
                o_box_idx    = r_count[IW-1:0];
                o_cmd.store  = in_acc && has_room;
                o_cmd.mark_clr_all = in_acc && i_final;
            end
            SORT_RDI:  o_cmd.box_rd = 1'b1;
            SORT_LDI:  o_cmd.score_ld = 1'b1;
            SORT_RDJ: begin
                o_box_idx    = r_j[IW-1:0];
                o_cmd.box_rd = 1'b1;
            end
            SORT_CMPJ: ;
            SORT_WR: begin
                o_rank_idx    = r_cnt;
                o_cmd.rank_wr = 1'b1;
            end
            SUP_CHK:   o_cmd.rank_rd = (r_i != r_n) && !i_sts.mark_at;
            SUP_RA: begin
                o_cmd.box_rd      = 1'b1;
                o_cmd.box_by_rank = 1'b1;
            end
            SUP_LA:    o_cmd.a_ld = 1'b1;
            PAIR_CHK: begin
                o_mark_idx    = r_j[IW-1:0];
                o_rank_idx    = r_j[IW-1:0];
                o_cmd.rank_rd = (r_j != r_n) && !i_sts.mark_at;
            end
            P_RB: begin
                o_cmd.box_rd      = 1'b1;
                o_cmd.box_by_rank = 1'b1;
            end
            P_SPAN:    o_cmd.span_ld = 1'b1;
            P_MUL:     o_cmd.mul_ld = 1'b1;
            P_UNI:     o_cmd.uni_ld = 1'b1;
            P_THR:     o_cmd.thr_ld = 1'b1;
            P_CMP: begin
                o_mark_idx     = r_j[IW-1:0];
                o_cmd.mark_set = i_sts.hit;
            end
            SCAN: ;
            EMIT_CHK:  o_cmd.rank_rd = (r_i != r_n) && !i_sts.mark_at;
            EMIT_RB: begin
                o_cmd.box_rd      = 1'b1;
                o_cmd.box_by_rank = 1'b1;
            end
            EMIT_LD:   o_cmd.out_ld = 1'b1;
            EMIT_WAIT: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= LOAD;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_n     <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_cnt   <= '0;
            r_last  <= '0;
        end else begin
            unique case (r_state)
                LOAD: begin
                    if (in_acc) begin
                        if (has_room) r_count <= r_count + CW'(1);
                        else r_ovf <= 1'b1;
                        if (i_final) begin
                            r_n     <= has_room ? r_count + CW'(1) : r_count;
                            r_i     <= '0;
                            r_state <= SORT_RDI;
                        end
                    end
                end
                SORT_RDI: r_state <= SORT_LDI;
                SORT_LDI: begin
                    r_j     <= '0;
                    r_cnt   <= '0;
                    r_state <= SORT_RDJ;
                end
                SORT_RDJ: r_state <= SORT_CMPJ;
                SORT_CMPJ: begin
                    // rank = boxes with higher score, or equal score and earlier arrival
                    if (i_sts.sc_gt || (i_sts.sc_eq && r_j < r_i)) r_cnt <= r_cnt + IW'(1);
                    r_j     <= j_nxt;
                    r_state <= (j_nxt == r_n) ? SORT_WR : SORT_RDJ;
                end
                SORT_WR: begin
                    if (i_nxt == r_n) begin
                        r_i     <= '0;
                        r_state <= SUP_CHK;
                    end else begin
                        r_i     <= i_nxt;
                        r_state <= SORT_RDI;
                    end
                end
                SUP_CHK: begin
                    if (r_i == r_n) begin
                        r_i     <= '0;
                        r_state <= SCAN;
                    end else if (i_sts.mark_at) begin
                        r_i <= i_nxt;
                    end else begin
                        r_state <= SUP_RA;
                    end
                end
                SUP_RA: r_state <= SUP_LA;
                SUP_LA: begin
                    r_j     <= i_nxt;
                    r_state <= PAIR_CHK;
                end
                PAIR_CHK: begin
                    if (r_j == r_n) begin
                        r_i     <= i_nxt;
                        r_state <= SUP_CHK;
                    end else if (i_sts.mark_at) begin
                        r_j <= j_nxt;
                    end else begin
                        r_state <= P_RB;
                    end
                end
                P_RB:   r_state <= P_SPAN;
                P_SPAN: r_state <= P_MUL;
                P_MUL:  r_state <= P_UNI;
                P_UNI:  r_state <= P_THR;
                P_THR:  r_state <= P_CMP;
                P_CMP: begin
                    r_j     <= j_nxt;
                    r_state <= PAIR_CHK;
                end
                SCAN: begin
                    if (!i_sts.mark_at) r_last <= r_i[IW-1:0];
                    if (i_nxt == r_n) begin
                        r_i     <= '0;
                        r_state <= EMIT_CHK;
                    end else begin
                        r_i <= i_nxt;
                    end
                end
                EMIT_CHK: begin
                    if (r_i == r_n) begin
                        r_count <= '0;
                        r_ovf   <= 1'b0;
                        r_state <= LOAD;
                    end else if (i_sts.mark_at) begin
                        r_i <= i_nxt;
                    end else begin
                        r_state <= EMIT_RB;
                    end
                end
                EMIT_RB: r_state <= EMIT_LD;
                EMIT_LD: r_state <= EMIT_WAIT;
                EMIT_WAIT: begin
                    if (i_sts.out_taken) begin
                        r_i     <= i_nxt;
                        r_state <= EMIT_CHK;
                    end
                end
                default: r_state <= LOAD;
            endcase
        end
    end

endmodule

/* sv/box_non_max_suppression.sv */
// greedy non-maximum suppression over a batch of up to MAX_BOXES boxes
// input channel (i_in_valid/o_in_ready): one box per transaction; the box
//   with i_final_box set closes the batch. boxes past capacity are dropped
//   and reported on o_batch_overflow of every result of that batch
// output channel (o_out_valid/i_out_ready): one transaction per surviving
//   box in descending score order (ties in arrival order), o_last_kept on
//   the final one
// config channel (i_cfg_valid/o_cfg_ready, always ready): iou threshold,
//   unsigned Q1.16, write only while the block is idle
// boxes load at one per cycle. after the final box the ranking pass reads
//   the box memory once per compare, each overlap test of a pair steps
//   through read, span, multiply, union, threshold and compare, then each
//   result is read, loaded and held until the receiver takes it. input is
//   not taken until the last result of the batch has gone
// a stalled receiver simply holds the block in its output wait state
// reset: threshold returns to 0.5, the batch is empty, no result pending
module box_non_max_suppression
    import bnms_pkg::*;
#(
    parameter int MAX_BOXES = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [COORD_W-1:0] i_left_edge,
    input  logic [COORD_W-1:0] i_top_edge,
    input  logic [COORD_W-1:0] i_right_edge,
    input  logic [COORD_W-1:0] i_bottom_edge,
    input  logic [COORD_W-1:0] i_confidence,
    input  logic               i_final_box,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [COORD_W-1:0] o_kept_left,
    output logic [COORD_W-1:0] o_kept_top,
    output logic [COORD_W-1:0] o_kept_right,
    output logic [COORD_W-1:0] o_kept_bottom,
    output logic [COORD_W-1:0] o_kept_score,
    output logic [SLOT_W-1:0]  o_arrival_slot,
    output logic               o_batch_overflow,
    output logic               o_last_kept,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [THR_W-1:0]   i_cfg_data
);

    localparam int IW = $clog2(MAX_BOXES);

    t_cmd          cmd;
    t_sts          sts;
    logic [IW-1:0] box_idx, rank_idx, rank_wdata, mark_idx;
    t_box          in_box, out_box;

    assign in_box = '{x0: i_left_edge, y0: i_top_edge, x1: i_right_edge,
                      y1: i_bottom_edge, sc: i_confidence};
    assign o_cfg_ready = 1'b1;

    bnms_ctrl #(.MAX_BOXES(MAX_BOXES)) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_final      (i_final_box),
        .o_in_ready   (o_in_ready),
        .i_sts        (sts),
        .o_cmd        (cmd),
        .o_box_idx    (box_idx),
        .o_rank_idx   (rank_idx),
        .o_rank_wdata (rank_wdata),
        .o_mark_idx   (mark_idx)
    );

    bnms_dp #(.MAX_BOXES(MAX_BOXES)) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_box_idx    (box_idx),
        .i_rank_idx   (rank_idx),
        .i_rank_wdata (rank_wdata),
        .i_mark_idx   (mark_idx),
        .i_box        (in_box),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_out_ready  (i_out_ready),
        .o_sts        (sts),
        .o_out_valid  (o_out_valid),
        .o_out_box    (out_box),
        .o_out_slot   (o_arrival_slot),
        .o_out_ovf    (o_batch_overflow),
        .o_out_last   (o_last_kept)
    );

    assign o_kept_left   = out_box.x0;
    assign o_kept_top    = out_box.y0;
    assign o_kept_right  = out_box.x1;
    assign o_kept_bottom = out_box.y1;
    assign o_kept_score  = out_box.sc;

endmodule

/* sv/bnms_checker.sv */
module bnms_checker
    import bnms_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               i_final_box,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic [COORD_W-1:0] o_kept_score,
    input logic               o_last_kept
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped before transaction");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_kept_score) && $stable(o_last_kept))
        else $error("result changed while stalled");

    a_no_load_while_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input taken while results pending");

    a_no_result_mid_batch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && !i_final_box |=> !o_out_valid)
        else $error("result before batch closed");

endmodule

bind box_non_max_suppression bnms_checker u_bnms_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .i_final_box  (i_final_box),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_kept_score (o_kept_score),
    .o_last_kept  (o_last_kept)
);
